FILE: sv/ftmc_pkg.sv
// ----------------------------------------------------------------------------
// ftmc_pkg
// Shared types, codes and helpers for the fuzzy tag match counter.
// ----------------------------------------------------------------------------
package ftmc_pkg;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_COUNT_BITS  = 16;
   localparam int TAG_BITS        = 96;
   localparam int HALF_BITS       = TAG_BITS / 2;

   localparam logic [6:0] THRESHOLD_RESET = 7'd87;

   // op codes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_COUNT = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic        op;
      logic [31:0] tag_header;
      logic [47:0] tag_code;
      logic [15:0] tag_check;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  entry_index;
      logic [6:0]  best_score;
      logic [15:0] pass_count;
   } rsp_type;

   // population count of a 6-bit slice
   function automatic logic [2:0] ones6(input logic [5:0] v);
      logic [2:0] n;
      n = '0;
      for (int b = 0; b < 6; b++) begin
         n = n + {2'b00, v[b]};
      end
      return n;
   endfunction

   // population count of a 48-bit half tag, eight 6-bit slices
   function automatic logic [5:0] ones48(input logic [47:0] v);
      logic [5:0] n;
      n = '0;
      for (int c = 0; c < 8; c++) begin
         n = n + {3'b000, ones6(v[c*6 +: 6])};
      end
      return n;
   endfunction

endpackage

FILE: sv/fuzzy_tag_match_counter.sv
// ----------------------------------------------------------------------------
// fuzzy_tag_match_counter
// Table of 96-bit tags with saturating pass counters and nearest-match lookup.
// ----------------------------------------------------------------------------
// An add beat (op 0) stores the tag in the next free row, if any, with its
// counter at zero and answers in the cycle after acceptance; busy stays low,
// so adds can be issued every cycle. A count beat (op 1) on an empty table
// answers likewise. A count beat on a table of N rows raises busy and walks
// the tag memory one row per cycle through a shared XOR/popcount/compare
// unit; the result strobe follows the scan, drain, fetch and update states,
// busy drops in the same cycle, and the scan length is set by the single tag
// memory read port. Results are shown for exactly one cycle on rsp_strobe and
// cannot be stalled. The user must write match_threshold (reset value 87)
// via csr_wr_en/csr_wr_data only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module fuzzy_tag_match_counter
   import ftmc_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // storage: tag rows and pass counters, no reset (rows read only once written)
   logic [TAG_BITS-1:0]   tag_mem [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    used_ff;
   logic [6:0]          thr_ff;
   logic [TAG_BITS-1:0] key_ff;
   logic [CNT_W-1:0]    scan_ff;

   // scan pipeline: read -> popcount halves -> score compare
   logic                s1_vld_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [TAG_BITS-1:0] tag_rd_ff;
   logic                s2_vld_ff;
   logic [IDX_W-1:0]    s2_idx_ff;
   logic [5:0]          pop_a_ff;
   logic [5:0]          pop_b_ff;
   logic [6:0]          score;

   logic [6:0]       best_ff;
   logic [IDX_W-1:0] best_idx_ff;

   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [COUNT_BITS-1:0] cnt_new;

   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  table_full;
   logic                  scan_last;
   logic                  found;
   logic                  add_wr;
   logic                  cnt_wr;
   logic [IDX_W-1:0]      cnt_wr_addr;
   logic [COUNT_BITS-1:0] cnt_wr_data;
   logic [31:0]           used_wide;
   logic [31:0]           best_idx_wide;
   logic [31:0]           cnt_wide;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign table_full = (used_ff == CNT_W'(TABLE_DEPTH));
   assign scan_last  = ((scan_ff + CNT_W'(1)) == used_ff);
   assign found      = (best_ff >= thr_ff);
   assign cnt_new    = (cnt_rd_ff == '1) ? cnt_rd_ff : cnt_rd_ff + COUNT_BITS'(1);
   assign score      = 7'(TAG_BITS) - ({1'b0, pop_a_ff} + {1'b0, pop_b_ff});

   assign used_wide     = 32'(used_ff);
   assign best_idx_wide = 32'(best_idx_ff);
   assign cnt_wide      = 32'(cnt_new);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      add_wr        = 1'b0;
      cnt_wr        = 1'b0;
      cnt_wr_addr   = used_ff[IDX_W-1:0];
      cnt_wr_data   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_ADD) begin
                  rsp_strobe_in = 1'b1;
                  if (table_full) begin
                     rsp_data_in.status = STATUS_TABLE_FULL;
                  end else begin
                     add_wr                  = 1'b1;
                     cnt_wr                  = 1'b1;
                     rsp_data_in.status      = STATUS_OK;
                     rsp_data_in.entry_index = used_wide[3:0];
                  end
               end else if (used_ff == '0) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.status = STATUS_NOT_FOUND;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last row to leave the compare stage
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in               = ST_IDLE;
            rsp_strobe_in          = 1'b1;
            rsp_data_in.best_score = best_ff;
            if (found) begin
               cnt_wr                  = 1'b1;
               cnt_wr_addr             = best_idx_ff;
               cnt_wr_data             = cnt_new;
               rsp_data_in.status      = STATUS_OK;
               rsp_data_in.entry_index = best_idx_wide[3:0];
               rsp_data_in.pass_count  = cnt_wide[15:0];
            end else begin
               rsp_data_in.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         thr_ff        <= THRESHOLD_RESET;
         rsp_strobe_ff <= 1'b0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         s1_vld_ff     <= (state_ff == ST_SCAN);
         s2_vld_ff     <= s1_vld_ff;
         if (add_wr) begin
            used_ff <= used_ff + CNT_W'(1);
         end
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // ---------------------------------------------------------------------
   // datapath registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         key_ff      <= {req_data.tag_header, req_data.tag_code, req_data.tag_check};
         scan_ff     <= '0;
         best_ff     <= '0;
         best_idx_ff <= '0;
      end else begin
         if (state_ff == ST_SCAN) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
         // strict greater keeps the lowest index on a tie
         if (s2_vld_ff && (score > best_ff)) begin
            best_ff     <= score;
            best_idx_ff <= s2_idx_ff;
         end
      end
      s1_idx_ff <= scan_ff[IDX_W-1:0];
      s2_idx_ff <= s1_idx_ff;
      pop_a_ff  <= ones48(tag_rd_ff[TAG_BITS-1:HALF_BITS] ^ key_ff[TAG_BITS-1:HALF_BITS]);
      pop_b_ff  <= ones48(tag_rd_ff[HALF_BITS-1:0] ^ key_ff[HALF_BITS-1:0]);
   end

   // tag memory: written on add, read once per scan cycle
   always_ff @(posedge clock) begin
      if (add_wr) begin
         tag_mem[used_ff[IDX_W-1:0]] <= {req_data.tag_header, req_data.tag_code,
                                         req_data.tag_check};
      end
      tag_rd_ff <= tag_mem[scan_ff[IDX_W-1:0]];
   end

   // counter memory: cleared on add, read-modify-write on a match
   always_ff @(posedge clock) begin
      if (cnt_wr) begin
         cnt_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      if (state_ff == ST_FETCH) begin
         cnt_rd_ff <= cnt_mem[best_idx_ff];
      end
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_DEPTH))
      else $error("row count beyond table depth");

   a_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> !s1_vld_ff && !s2_vld_ff)
      else $error("counter fetch before scan pipeline drained");

   a_match_score: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STATUS_OK && rsp_data.best_score != 7'd0
      |-> rsp_data.best_score >= thr_ff)
      else $error("match reported below threshold");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != STATUS_OK
      |-> rsp_data.entry_index == 4'd0 && rsp_data.pass_count == 16'd0)
      else $error("miss carries index or counter");

endmodule
